/* rtl/rmedf_pkg.sv */
// ----------------------------------------------------------------------------
// rmedf_pkg: shared types and constants
// Task entry layout, sequencer states and codes of the tick scheduler.
// ----------------------------------------------------------------------------
package rmedf_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int TIME_WIDTH = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int STAT_W     = 32;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_LOAD   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] period;
        logic [TIME_WIDTH-1:0] burst;
        logic [TIME_WIDTH-1:0] deadline;
        logic [TIME_WIDTH-1:0] phase;
        logic [TIME_WIDTH-1:0] work;
        logic [TIME_WIDTH-1:0] countdown;
        logic [STAT_W-1:0]     lost;
        logic [STAT_W-1:0]     done;
    } task_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_READ,
        OP_SCAN,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic active;   // entry index below task count
        logic hit;      // entry is the addressed or picked one
        logic mode;     // 1 = EDF
    } unit_ctl_t;

    typedef struct packed {
        logic                  miss;
        logic                  cand;
        logic [TIME_WIDTH-1:0] key;
        logic                  done;
    } unit_flags_t;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
        sat_inc = (&v) ? v : v + STAT_W'(1);
    endfunction

endpackage

/* rtl/rmedf_cell.sv */
// ----------------------------------------------------------------------------
// rmedf_cell: one slot of the task ring
// Holds one task entry and takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module rmedf_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift,
    input  rmedf_pkg::task_t d,
    output rmedf_pkg::task_t q
);

    rmedf_pkg::task_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (shift) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

/* rtl/rmedf_unit.sv */
// ----------------------------------------------------------------------------
// rmedf_unit: head-of-ring update
// Applies load, miss/release, or run/countdown to the entry at the ring head.
// ----------------------------------------------------------------------------
module rmedf_unit (
    input  rmedf_pkg::unit_ctl_t                  ctl,
    input  logic [rmedf_pkg::TIME_WIDTH-1:0]      ld_period,
    input  logic [rmedf_pkg::TIME_WIDTH-1:0]      ld_burst,
    input  logic [rmedf_pkg::TIME_WIDTH-1:0]      ld_deadline,
    input  rmedf_pkg::task_t                      ent_in,
    output rmedf_pkg::task_t                      ent_out,
    output rmedf_pkg::unit_flags_t                flags
);

    always_comb begin
        ent_out = ent_in;
        flags   = '0;
        case (ctl.op)
            rmedf_pkg::OP_LOAD: begin
                if (ctl.hit) begin
                    ent_out          = '0;
                    ent_out.period   = ld_period;
                    ent_out.burst    = ld_burst;
                    ent_out.deadline = ld_deadline;
                end
            end
            rmedf_pkg::OP_SCAN: begin
                if (ctl.active) begin
                    if (ent_in.work != '0 && ent_in.countdown == '0) begin
                        ent_out.lost = rmedf_pkg::sat_inc(ent_in.lost);
                        ent_out.work = '0;
                        flags.miss   = 1'b1;
                    end
                    if (ent_in.phase == '0) begin
                        ent_out.work      = ent_in.burst;
                        ent_out.countdown = ent_in.deadline;
                        // period zero acts as period one
                        ent_out.phase     = (ent_in.period == '0) ? '0
                                            : ent_in.period - 1'b1;
                    end else begin
                        ent_out.phase = ent_in.phase - 1'b1;
                    end
                    flags.cand = (ent_out.work != '0);
                end
                flags.key = ctl.mode ? ent_out.countdown : ent_out.period;
            end
            rmedf_pkg::OP_UPDATE: begin
                if (ctl.active) begin
                    if (ctl.hit) begin
                        ent_out.work = ent_in.work - 1'b1;
                        if (ent_out.work == '0) begin
                            ent_out.done = rmedf_pkg::sat_inc(ent_in.done);
                            flags.done   = 1'b1;
                        end
                    end
                    if (ent_in.countdown != '0) begin
                        ent_out.countdown = ent_in.countdown - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/rm_edf_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// rm_edf_tick_scheduler: periodic task scheduler, rate monotonic or EDF
// The sixteen task entries sit in a ring of cells that rotates one place per
// cycle past a single update unit at its head. A load or a read takes one
// full rotation, a tick takes two (misses, releases and priority pick on the
// first, running the pick and counting down deadlines on the second). The
// result beat is then posted in the output state, and the next item is taken
// in the idle state. One item is worked at a time; a new item is taken while
// the last result beat still waits at the output.
// ----------------------------------------------------------------------------
module rm_edf_tick_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] task_index, [19:4] task_period, [35:20] task_burst,
    // [51:36] task_deadline, [55:52] zero
    input  logic [55:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] running_task, [4] cpu_idle, [5] job_done, [21:6] miss_mask,
    // [53:22] stat_lost, [85:54] stat_completed, [86] stat_pending, [87] zero
    output logic [87:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_wdata
);

    localparam int N  = rmedf_pkg::MAX_TASKS;
    localparam int TW = rmedf_pkg::TIME_WIDTH;

    rmedf_pkg::state_t state_reg, state_next;

    logic                        mode_reg;
    logic [rmedf_pkg::CNT_W-1:0] count_reg;
    logic [rmedf_pkg::CNT_W-1:0] n_eff;

    logic [rmedf_pkg::IDX_W-1:0] step_reg;
    logic [1:0]                  kind_reg;
    logic [rmedf_pkg::IDX_W-1:0] idx_reg;
    logic [TW-1:0]               ld_period_reg, ld_burst_reg, ld_deadline_reg;

    logic                        found_reg;
    logic [rmedf_pkg::IDX_W-1:0] best_reg;
    logic [TW-1:0]               best_key_reg;
    logic [N-1:0]                miss_reg;
    logic                        done_reg;
    logic [31:0]                 rd_lost_reg, rd_done_reg;
    logic                        rd_pend_reg;

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    rmedf_pkg::task_t       ring [N];
    rmedf_pkg::task_t       head_next;
    rmedf_pkg::unit_ctl_t   ctl;
    rmedf_pkg::unit_flags_t flags;
    logic                   shift;
    logic                   s_fire;
    logic                   last_step;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == rmedf_pkg::ST_IDLE);
    assign last_step = (&step_reg);
    assign n_eff     = (count_reg > rmedf_pkg::CNT_W'(N)) ? rmedf_pkg::CNT_W'(N) : count_reg;

    assign shift = (state_reg == rmedf_pkg::ST_LOAD) || (state_reg == rmedf_pkg::ST_READ)
                || (state_reg == rmedf_pkg::ST_SCAN) || (state_reg == rmedf_pkg::ST_UPDATE);

    // control to head unit; ring head holds entry step_reg
    always_comb begin
        ctl.mode   = mode_reg;
        ctl.active = ({1'b0, step_reg} < n_eff);
        ctl.hit    = 1'b0;
        ctl.op     = rmedf_pkg::OP_READ;
        unique case (state_reg)
            rmedf_pkg::ST_LOAD: begin
                ctl.op  = rmedf_pkg::OP_LOAD;
                ctl.hit = (step_reg == idx_reg);
            end
            rmedf_pkg::ST_SCAN:   ctl.op = rmedf_pkg::OP_SCAN;
            rmedf_pkg::ST_UPDATE: begin
                ctl.op  = rmedf_pkg::OP_UPDATE;
                ctl.hit = found_reg && (step_reg == best_reg);
            end
            default: ctl.op = rmedf_pkg::OP_READ;
        endcase
    end

    rmedf_unit u_unit (
        .ctl         (ctl),
        .ld_period   (ld_period_reg),
        .ld_burst    (ld_burst_reg),
        .ld_deadline (ld_deadline_reg),
        .ent_in      (ring[0]),
        .ent_out     (head_next),
        .flags       (flags)
    );

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_ring
            if (k == N-1) begin : g_tail
                rmedf_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift(shift),
                    .d(head_next), .q(ring[k])
                );
            end else begin : g_mid
                rmedf_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift(shift),
                    .d(ring[k+1]), .q(ring[k])
                );
            end
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rmedf_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        rmedf_pkg::KIND_TICK: state_next = rmedf_pkg::ST_SCAN;
                        rmedf_pkg::KIND_LOAD: state_next = rmedf_pkg::ST_LOAD;
                        rmedf_pkg::KIND_READ: state_next = rmedf_pkg::ST_READ;
                        default:              state_next = rmedf_pkg::ST_OUT;
                    endcase
                end
            end
            rmedf_pkg::ST_SCAN:   if (last_step) state_next = rmedf_pkg::ST_UPDATE;
            rmedf_pkg::ST_LOAD,
            rmedf_pkg::ST_READ,
            rmedf_pkg::ST_UPDATE: if (last_step) state_next = rmedf_pkg::ST_OUT;
            rmedf_pkg::ST_OUT:    if (!m_tvalid_reg || m_tready) state_next = rmedf_pkg::ST_IDLE;
            default:              state_next = rmedf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmedf_pkg::ST_IDLE;
            mode_reg  <= 1'b0;
            count_reg <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_addr == rmedf_pkg::CFG_MODE) mode_reg <= cfg_wdata[0];
                else                                 count_reg <= cfg_wdata;
            end
            step_reg <= shift ? step_reg + 1'b1 : '0;
        end
    end

    // item capture and per-pass accumulators
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg        <= s_tuser;
            idx_reg         <= s_tdata[3:0];
            ld_period_reg   <= s_tdata[19:4];
            ld_burst_reg    <= s_tdata[35:20];
            ld_deadline_reg <= s_tdata[51:36];
            found_reg       <= 1'b0;
            best_reg        <= '0;
            best_key_reg    <= '0;
            miss_reg        <= '0;
            done_reg        <= 1'b0;
            rd_lost_reg     <= '0;
            rd_done_reg     <= '0;
            rd_pend_reg     <= 1'b0;
        end else begin
            if (state_reg == rmedf_pkg::ST_SCAN) begin
                miss_reg[step_reg] <= flags.miss;
                // strict compare keeps the lowest index on ties
                if (flags.cand && (!found_reg || flags.key < best_key_reg)) begin
                    found_reg    <= 1'b1;
                    best_reg     <= step_reg;
                    best_key_reg <= flags.key;
                end
            end
            if (state_reg == rmedf_pkg::ST_UPDATE && flags.done) done_reg <= 1'b1;
            if (state_reg == rmedf_pkg::ST_READ && step_reg == idx_reg) begin
                rd_lost_reg <= ring[0].lost;
                rd_done_reg <= ring[0].done;
                rd_pend_reg <= (ring[0].work != '0);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == rmedf_pkg::ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rmedf_pkg::ST_OUT && (!m_tvalid_reg || m_tready)) begin
            if (kind_reg == rmedf_pkg::KIND_TICK) begin
                m_tdata_reg <= {66'd0, miss_reg, done_reg, !found_reg, best_reg};
            end else if (kind_reg == rmedf_pkg::KIND_READ) begin
                m_tdata_reg <= {1'b0, rd_pend_reg, rd_done_reg, rd_lost_reg, 22'd0};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // an idle tick runs nothing
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> (m_tdata[3:0] == '0 && !m_tdata[5]))
        else $error("idle tick reports a running task");

    // ring sits at step zero whenever no pass is under way
    a_step_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmedf_pkg::ST_IDLE) |-> (step_reg == '0))
        else $error("ring left misaligned");

    // accepted item closes the input until it is done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second item taken while busy");

    // picked task must lie inside the active range
    a_pick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmedf_pkg::ST_UPDATE && found_reg) |-> ({1'b0, best_reg} < n_eff))
        else $error("pick outside active tasks");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rm_edf_tick_scheduler
// Drives loads, ticks, reads and unused kinds from a directed table and then
// random task sets in both scheduling modes. A predictor built into the bench
// or a fixed table value gives every result beat; a mismatch lists each field.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic        pad;
        logic        pending;
        logic [31:0] completed;
        logic [31:0] lost;
        logic [15:0] miss;
        logic        done;
        logic        idle;
        logic [3:0]  running;
    } sched_result_t;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  idx;
        logic [15:0] period;
        logic [15:0] burst;
        logic [15:0] deadline;
        logic        use_fixed;    // compare against fixed value below
        logic [87:0] fixed;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    always #1 aclk = ~aclk;

    rm_edf_tick_scheduler dut (.*);

    // predictor state
    logic        mdl_mode;
    logic [4:0]  mdl_count;
    logic [15:0] per_tab [16];
    logic [15:0] bur_tab [16];
    logic [15:0] dl_tab [16];
    logic [15:0] phase_q [16];
    logic [15:0] work_q [16];
    logic [15:0] cdown_q [16];
    logic [31:0] lost_q [16];
    logic [31:0] done_q [16];

    logic [87:0] expected_beats[$];
    int          failures = 0;
    int          idle_pct = 26;
    int          stall_hold = 0;
    int          hold_req = 0;
    int          hold_ack = 0;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    function automatic logic [87:0] schedule_step(logic [1:0] kind, logic [3:0] idx,
                                                  logic [15:0] p, logic [15:0] b,
                                                  logic [15:0] d);
        sched_result_t r;
        int          n;
        bit          found;
        int          pick;
        logic [15:0] ka, kb;
        r = '0;
        n = (mdl_count > 16) ? 16 : mdl_count;
        found = 0;
        pick = 0;
        if (kind == rmedf_pkg::KIND_LOAD) begin
            per_tab[idx] = p; bur_tab[idx] = b; dl_tab[idx] = d;
            phase_q[idx] = 0; work_q[idx] = 0; cdown_q[idx] = 0;
            lost_q[idx] = 0; done_q[idx] = 0;
        end else if (kind == rmedf_pkg::KIND_READ) begin
            r.lost = lost_q[idx];
            r.completed = done_q[idx];
            r.pending = work_q[idx] != 0;
        end else if (kind == rmedf_pkg::KIND_TICK) begin
            for (int i = 0; i < n; i++)
                if (work_q[i] != 0 && cdown_q[i] == 0) begin
                    lost_q[i] = bump(lost_q[i]);
                    work_q[i] = 0;
                    r.miss[i] = 1'b1;
                end
            for (int i = 0; i < n; i++)
                if (phase_q[i] == 0) begin
                    work_q[i] = bur_tab[i];
                    cdown_q[i] = dl_tab[i];
                    phase_q[i] = (per_tab[i] == 0) ? 16'd0 : per_tab[i] - 16'd1;
                end else begin
                    phase_q[i]--;
                end
            for (int i = 0; i < n; i++) begin
                if (work_q[i] == 0) continue;
                ka = mdl_mode ? cdown_q[i] : per_tab[i];
                kb = mdl_mode ? cdown_q[pick] : per_tab[pick];
                if (!found || ka < kb) begin
                    pick = i;
                    found = 1;
                end
            end
            if (found) begin
                work_q[pick]--;
                if (work_q[pick] == 0) begin
                    done_q[pick] = bump(done_q[pick]);
                    r.done = 1'b1;
                end
                r.running = pick[3:0];
            end
            r.idle = !found;
            for (int i = 0; i < n; i++)
                if (cdown_q[i] != 0) cdown_q[i]--;
        end
        return r;
    endfunction

    // result side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            stall_hold <= 300;
            m_tready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, m_tdata);
                failures++;
            end else begin
                sched_result_t e, a;
                e = expected_beats.pop_front();
                a = m_tdata;
                if (e !== a) begin
                    failures++;
                    $display("%0t: mismatch exp %h got %h", $time, e, a);
                    if (e.running !== a.running)
                        $display("  running_task exp %0d got %0d", e.running, a.running);
                    if (e.idle !== a.idle)
                        $display("  cpu_idle exp %0d got %0d", e.idle, a.idle);
                    if (e.done !== a.done)
                        $display("  job_done exp %0d got %0d", e.done, a.done);
                    if (e.miss !== a.miss)
                        $display("  miss_mask exp %h got %h", e.miss, a.miss);
                    if (e.lost !== a.lost)
                        $display("  stat_lost exp %0d got %0d", e.lost, a.lost);
                    if (e.completed !== a.completed)
                        $display("  stat_completed exp %0d got %0d", e.completed,
                                 a.completed);
                    if (e.pending !== a.pending)
                        $display("  stat_pending exp %0d got %0d", e.pending, a.pending);
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] kind, logic [3:0] idx, logic [15:0] p,
                             logic [15:0] b, logic [15:0] d);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'd0, d, b, p, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_beats.push_back(schedule_step(kind, idx, p, b, d));
    endtask

    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_cfg(logic addr, logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == rmedf_pkg::CFG_MODE) mdl_mode = val[0];
        else mdl_count = val;
    endtask

    // loads every active entry, with mostly short periods so jobs keep coming
    task automatic load_task_set(int n);
        logic [15:0] p, b, d;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: begin p = 16'hFFFF; b = 16'hFFFF; d = 16'hFFFF; end
                1: begin p = 16'($urandom); b = 16'($urandom); d = 16'($urandom); end
                2: begin p = 16'd0; b = 16'($urandom_range(2)); d = 16'd0; end
                default: begin
                    p = 16'($urandom_range(1, 12));
                    b = 16'($urandom_range(0, 4));
                    d = 16'($urandom_range(1, 12));
                end
            endcase
            send_beat(rmedf_pkg::KIND_LOAD, i[3:0], p, b, d);
        end
    endtask

    stim_row_t plan[$];

    initial begin
        int n;
        mdl_mode = 0;
        mdl_count = 0;
        for (int i = 0; i < 16; i++) begin
            per_tab[i] = 0; bur_tab[i] = 0; dl_tab[i] = 0; phase_q[i] = 0;
            work_q[i] = 0; cdown_q[i] = 0; lost_q[i] = 0; done_q[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: count zero tick idles, reads after reset are zero, kind 3
        plan.push_back('{rmedf_pkg::KIND_TICK, 0, 0, 0, 0, 1, 88'h10});
        plan.push_back('{rmedf_pkg::KIND_READ, 15, 0, 0, 0, 1, 88'h0});
        plan.push_back('{rmedf_pkg::KIND_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         1, 88'h0});
        plan.push_back('{rmedf_pkg::KIND_LOAD, 0, 16'd4, 16'd2, 16'd3, 1, 88'h0});
        plan.push_back('{rmedf_pkg::KIND_LOAD, 1, 16'd0, 16'd1, 16'd0, 1, 88'h0});
        plan.push_back('{rmedf_pkg::KIND_LOAD, 2, 16'd3, 16'd0, 16'd1, 1, 88'h0});
        plan.push_back('{rmedf_pkg::KIND_LOAD, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 88'h0});
        for (int i = 4; i < 15; i++)
            plan.push_back('{rmedf_pkg::KIND_LOAD, i[3:0], 16'd5, 16'd1, 16'd5, 1, 88'h0});
        plan.push_back('{rmedf_pkg::KIND_LOAD, 15, 16'd1, 16'd5, 16'd1, 1, 88'h0});
        foreach (plan[k]) begin
            send_beat(plan[k].kind, plan[k].idx, plan[k].period, plan[k].burst,
                      plan[k].deadline);
            if (plan[k].use_fixed)
                expected_beats[expected_beats.size() - 1] = plan[k].fixed;
        end
        drain_idle();
        write_cfg(rmedf_pkg::CFG_COUNT, 5'd31);    // above the table size acts as 16
        for (int m = 0; m < 2; m++) begin
            write_cfg(rmedf_pkg::CFG_MODE, m[4:0]);
            for (int k = 0; k < 6; k++) send_beat(rmedf_pkg::KIND_TICK, 0, 0, 0, 0);
            for (int k = 0; k < 16; k += 5)
                send_beat(rmedf_pkg::KIND_READ, k[3:0], 0, 0, 0);
            drain_idle();
        end

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: n = 16;
                1: n = 1;
                default: n = $urandom_range(2, 16);
            endcase
            write_cfg(rmedf_pkg::CFG_MODE, {4'd0, ph[0]});
            write_cfg(rmedf_pkg::CFG_COUNT, (ph == 11) ? 5'd0 : n[4:0]);
            load_task_set(n);
            idle_pct = (ph == 5) ? 0 : 26;
            if (ph == 3) hold_req++;
            for (int k = 0; k < 120; k++) begin
                case ($urandom_range(19))
                    0: send_beat(rmedf_pkg::KIND_READ, 4'($urandom), 0, 0, 0);
                    1: send_beat(rmedf_pkg::KIND_UNUSED, 4'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom));
                    2: send_beat(rmedf_pkg::KIND_LOAD, 4'($urandom_range(n - 1)),
                                 16'($urandom_range(1, 9)), 16'($urandom_range(0, 4)),
                                 16'($urandom_range(1, 9)));
                    default: send_beat(rmedf_pkg::KIND_TICK, 4'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom));
                endcase
            end
            for (int k = 0; k < 16; k++) send_beat(rmedf_pkg::KIND_READ, k[3:0], 0, 0, 0);
            idle_pct = 26;
            drain_idle();
        end
        drain_idle();
        if (failures == 0 && expected_beats.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
